// ----- rtl/tmq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_pkg: shared types and constants for the text marquee window scroller
// Command codes, config register indexes, transaction payload structs, FSM.
// ----------------------------------------------------------------------------
package tmq_pkg;

  localparam int TEXT_DEPTH_DEF = 256;
  localparam int WINDOW_MAX_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  SPACE_CHAR  = 8'h20;
  localparam int          SMOOTH_STEP = 2;
  localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

  // config register reset values
  localparam logic [5:0]  WINDOW_CHARS_RST = 6'd16;
  localparam logic [15:0] SCROLL_INT_RST   = 16'd200;
  localparam logic [15:0] PAUSE_INT_RST    = 16'd1000;
  localparam logic        LOOP_MODE_RST    = 1'b1;
  localparam logic        SMOOTH_MODE_RST  = 1'b1;
  localparam logic [4:0]  GLYPH_PIX_RST    = 5'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_CHARS = 3'd0,
    REG_SCROLL_INT   = 3'd1,
    REG_PAUSE_INT    = 3'd2,
    REG_LOOP_MODE    = 3'd3,
    REG_SMOOTH_MODE  = 3'd4,
    REG_GLYPH_PIXELS = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_PAUSE  = 2'd2,
    CMD_RESUME = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] char_code;
    logic       text_begin;
    logic       text_finish;
  } in_item_t;

  typedef struct packed {
    logic [7:0] window_char;
    logic [5:0] window_slot;
    logic       window_last;
    logic [3:0] pixel_shift;
    logic [7:0] start_index;
    logic       moving;
  } out_item_t;

endpackage : tmq_pkg
`default_nettype wire

// ----- rtl/tmq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module tmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tmq_ram
`default_nettype wire

// ----- rtl/text_marquee_window_scroller_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_marquee_window_scroller_unit: scrolling text marquee window engine
// Holds a text in a RAM, runs pause and scroll timers off millisecond ticks,
// and streams the visible window one character per output transaction.
// ----------------------------------------------------------------------------
// Usage: a load, tick, pause or resume command that produces no window is
// just accepted. A finishing load or a tick that makes a scroll step is
// accepted, its window planned in ST_PLAN, then emitted in ST_EMIT at one
// character per cycle (up to window_chars + 2, i.e. 34 at WINDOW_MAX = 32)
// while the consumer keeps out_ready high; the single read port of the text
// RAM sets that one-character-per-cycle pace. The next command is taken as
// soon as the last character read has been issued, while that last character
// may still sit in the output register. The text store is not cleared at
// reset: there is no clearing pass and the block is ready right after reset.
// Configuration writes are registered and must only be made while idle.
// ----------------------------------------------------------------------------
module text_marquee_window_scroller_unit
  import tmq_pkg::*;
#(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command transactions
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire in_item_t              in_item,
  // window character transactions
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      out_item_t             out_item,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // AW: text address, CW: text count (0..TEXT_DEPTH),
  // NW: window character counts (0..WINDOW_MAX+2), XW: common compare width
  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int CW = $clog2(TEXT_DEPTH + 1);
  localparam int NW = $clog2(WINDOW_MAX + 3);
  localparam int XW = (CW > NW) ? CW : NW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [5:0]  cfg_window;
  logic [15:0] cfg_scroll;
  logic [15:0] cfg_pause;
  logic        cfg_loop;
  logic        cfg_smooth;
  logic [4:0]  cfg_glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_window <= WINDOW_CHARS_RST;
      cfg_scroll <= SCROLL_INT_RST;
      cfg_pause  <= PAUSE_INT_RST;
      cfg_loop   <= LOOP_MODE_RST;
      cfg_smooth <= SMOOTH_MODE_RST;
      cfg_glyph  <= GLYPH_PIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_CHARS: cfg_window <= cfg_data[5:0];
        REG_SCROLL_INT:   cfg_scroll <= cfg_data;
        REG_PAUSE_INT:    cfg_pause  <= cfg_data;
        REG_LOOP_MODE:    cfg_loop   <= cfg_data[0];
        REG_SMOOTH_MODE:  cfg_smooth <= cfg_data[0];
        REG_GLYPH_PIXELS: cfg_glyph  <= cfg_data[4:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Effective window width: 0 acts as 1, clamp at WINDOW_MAX
  logic [5:0] weff;
  always_comb begin
    if (cfg_window == 6'd0) begin
      weff = 6'd1;
    end else if (cfg_window > 6'(WINDOW_MAX)) begin
      weff = 6'(WINDOW_MAX);
    end else begin
      weff = cfg_window;
    end
  end

  // --------------------------------------------------------------------------
  // Marquee state
  // --------------------------------------------------------------------------
  state_t        state, state_next;
  logic [CW-1:0] text_count, text_count_next;
  logic [AW-1:0] start_pos, start_pos_next;   // always below TEXT_DEPTH
  logic [4:0]    pixel_pos, pixel_pos_next;
  logic          held, held_next;
  logic [15:0]   pause_timer, pause_timer_next;
  logic [15:0]   step_timer, step_timer_next;
  logic          overflowing, overflowing_next;

  logic accept;
  logic emit_go;   // accepted transaction produces a window

  // RAM write port (loads only, issued at accept)
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;

  // --------------------------------------------------------------------------
  // Command processing
  // --------------------------------------------------------------------------
  logic [CW-1:0] cnt_base;
  logic [CW-1:0] cnt_new;
  logic [15:0]   pt_inc;
  logic [15:0]   st_inc;
  logic [5:0]    pix_step;
  logic [CW-1:0] sp1;
  logic [XW-1:0] tc_x;
  logic [XW-1:0] w_x;
  logic [AW-1:0] end_pos;
  logic          do_advance;

  assign accept = in_valid && in_ready;

  always_comb begin
    cnt_base = in_item.text_begin ? '0 : text_count;
    cnt_new  = (cnt_base < CW'(TEXT_DEPTH)) ? cnt_base + CW'(1) : cnt_base;
    pt_inc   = (pause_timer == TIMER_MAX) ? pause_timer : pause_timer + 16'd1;
    st_inc   = (step_timer == TIMER_MAX) ? step_timer : step_timer + 16'd1;
    pix_step = {1'b0, pixel_pos} + 6'(SMOOTH_STEP);
    sp1      = CW'(start_pos) + CW'(1);
    tc_x     = XW'(text_count);
    w_x      = XW'(weff);
    // stop mode parks at length minus width, or at 0 for a short text
    if (cfg_loop) begin
      end_pos = '0;
    end else if (tc_x >= w_x) begin
      end_pos = AW'(tc_x - w_x);
    end else begin
      end_pos = '0;
    end
  end

  always_comb begin
    text_count_next  = text_count;
    start_pos_next   = start_pos;
    pixel_pos_next   = pixel_pos;
    held_next        = held;
    pause_timer_next = pause_timer;
    step_timer_next  = step_timer;
    overflowing_next = overflowing;
    ram_we           = 1'b0;
    ram_waddr        = cnt_base[AW-1:0];
    emit_go          = 1'b0;
    do_advance       = 1'b0;

    if (accept) begin
      case (in_item.command)
        CMD_LOAD: begin
          ram_we          = (cnt_base < CW'(TEXT_DEPTH));  // full store drops
          text_count_next = cnt_new;
          if (in_item.text_finish) begin
            start_pos_next   = '0;
            pixel_pos_next   = '0;
            held_next        = 1'b1;
            pause_timer_next = '0;
            step_timer_next  = '0;
            overflowing_next = (XW'(cnt_new) > w_x);
            emit_go          = 1'b1;
          end
        end
        CMD_PAUSE: begin
          held_next        = 1'b1;
          pause_timer_next = '0;
        end
        CMD_RESUME: begin
          held_next       = 1'b0;
          step_timer_next = '0;
        end
        CMD_TICK: begin
          if (overflowing) begin
            if (held) begin
              pause_timer_next = pt_inc;
              if (pt_inc >= cfg_pause) begin
                held_next       = 1'b0;
                step_timer_next = '0;
              end
            end else if (st_inc < cfg_scroll) begin
              step_timer_next = st_inc;
            end else begin
              step_timer_next = '0;
              emit_go         = 1'b1;
              if (cfg_smooth && (pix_step < {1'b0, cfg_glyph})) begin
                pixel_pos_next = pix_step[4:0];
              end else begin
                pixel_pos_next = cfg_smooth ? 5'd0 : pixel_pos;
                do_advance     = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // start advance with end-of-text handling
    if (do_advance) begin
      if (sp1 >= text_count) begin
        start_pos_next   = end_pos;
        held_next        = 1'b1;
        pause_timer_next = '0;
      end else begin
        start_pos_next = sp1[AW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Window plan: span from the start, then in loop mode a space and a wrap from 0
  // --------------------------------------------------------------------------
  logic [XW-1:0] avail_x, span_x, take_x, rem_x, lim_x;
  logic          plan_space;
  logic [NW-1:0] plan_n;
  logic [AW-1:0] plan_addr;

  always_comb begin
    avail_x    = (XW'(start_pos) < tc_x) ? tc_x - XW'(start_pos) : '0;
    span_x     = w_x + XW'(cfg_smooth);
    lim_x      = XW'(WINDOW_MAX + 2);
    rem_x      = '0;
    plan_space = 1'b0;
    if (!overflowing) begin
      take_x = (tc_x < lim_x) ? tc_x : lim_x;
    end else begin
      take_x = (avail_x < span_x) ? avail_x : span_x;
      if ((avail_x < span_x) && cfg_loop) begin
        plan_space = 1'b1;
        rem_x      = span_x - avail_x;
        if (rem_x > tc_x) begin
          rem_x = tc_x;
        end
      end
    end
    plan_n    = NW'(take_x + rem_x + XW'(plan_space));
    plan_addr = overflowing ? start_pos : '0;
  end

  // --------------------------------------------------------------------------
  // Emission sequencer: one character issued per cycle unless stalled; the RAM's
  // registered read data is the output register, held while the consumer stalls.
  // --------------------------------------------------------------------------
  logic [NW-1:0] a_left, b_left, idx, n_total;
  logic          space_pend;
  logic [AW-1:0] rd_addr;
  logic          issue, issue_space, issue_last, ram_re;
  logic          out_vld;
  logic          o_space, o_last, o_moving;
  logic [5:0]    o_slot;
  logic [3:0]    o_pshift;
  logic [7:0]    o_sindex;
  logic [31:0]   sp_wide;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && emit_go) state_next = ST_PLAN;
      ST_PLAN: state_next = (plan_n == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (issue && issue_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_EMIT: issue    = !out_vld || out_ready;
      default: ;
    endcase
    issue_space = issue && (a_left == '0) && space_pend;
    issue_last  = ((idx + NW'(1)) == n_total);
    ram_re      = issue && !issue_space;
  end

  assign sp_wide = 32'(start_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      text_count  <= '0;
      start_pos   <= '0;
      pixel_pos   <= '0;
      held        <= 1'b1;
      pause_timer <= '0;
      step_timer  <= '0;
      overflowing <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      state       <= state_next;
      text_count  <= text_count_next;
      start_pos   <= start_pos_next;
      pixel_pos   <= pixel_pos_next;
      held        <= held_next;
      pause_timer <= pause_timer_next;
      step_timer  <= step_timer_next;
      overflowing <= overflowing_next;
      if (issue) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // sequencer counters and per-character sideband
  always_ff @(posedge clk) begin
    if (state == ST_PLAN) begin
      a_left     <= NW'(take_x);
      b_left     <= NW'(rem_x);
      space_pend <= plan_space;
      rd_addr    <= plan_addr;
      idx        <= '0;
      n_total    <= plan_n;
    end else if (issue) begin
      idx <= idx + NW'(1);
      if (a_left != '0) begin
        a_left  <= a_left - NW'(1);
        rd_addr <= rd_addr + AW'(1);
      end else if (space_pend) begin
        space_pend <= 1'b0;
        rd_addr    <= '0;
      end else begin
        b_left  <= b_left - NW'(1);
        rd_addr <= rd_addr + AW'(1);
      end
    end
    // state is frozen during emission, so sample it per character
    if (issue) begin
      o_space  <= issue_space;
      o_slot   <= 6'(idx);
      o_last   <= issue_last;
      o_pshift <= (pixel_pos > 5'd15) ? 4'd15 : pixel_pos[3:0];
      o_sindex <= sp_wide[7:0];
      o_moving <= overflowing && !held;
    end
  end

  // Write and read never overlap: writes happen at accept, reads only while
  // emitting, so no forwarding is needed.
  tmq_ram #(
    .WIDTH (8),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_item.char_code),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_valid            = out_vld;
  assign out_item.window_char = o_space ? SPACE_CHAR : ram_rdata;
  assign out_item.window_slot = o_slot;
  assign out_item.window_last = o_last;
  assign out_item.pixel_shift = o_pshift;
  assign out_item.start_index = o_sindex;
  assign out_item.moving      = o_moving;

endmodule : text_marquee_window_scroller_unit
`default_nettype wire

// ----- rtl/tmq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmq_checker: port-level assertions for the marquee window scroller
// Watches window transactions for ordering and framing.
// ----------------------------------------------------------------------------
module tmq_checker
  import tmq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output changed while stalled");

  // no new command while a window is still mid-stream
  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.window_last |-> !in_ready)
    else $error("command taken during window emission");

  // slots count up within a window
  a_slot_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.window_last |=>
      !out_valid || (out_item.window_slot == $past(out_item.window_slot) + 6'd1))
    else $error("window slot out of sequence");

  // start index constant within a window
  a_start_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.window_last |=>
      !out_valid || (out_item.start_index == $past(out_item.start_index)))
    else $error("start index changed inside a window");

  // a window that follows right after the last character starts at slot 0
  a_first_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.window_last |=>
      !out_valid || (out_item.window_slot == 6'd0))
    else $error("window does not start at slot zero");

endmodule : tmq_checker

bind text_marquee_window_scroller_unit tmq_checker u_tmq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the text marquee window scroller
// Drives load, tick, pause and resume transactions, keeps its own copy of the
// marquee state to predict every window character, and checks each output
// transaction against the oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tmq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 130;
  localparam int unsigned CALM_AFTER    = 95;   // random items before idling stops
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned BACKLOG_HOLD  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  text_marquee_window_scroller_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Marquee mirror: text, scroll position, timers and register copies
  // --------------------------------------------------------------------------
  logic [7:0]  mq_text [0:TEXT_DEPTH_DEF-1];
  int unsigned mq_count   = 0;
  int unsigned mq_start   = 0;
  int unsigned mq_pixel   = 0;
  int unsigned mq_pause_t = 0;
  int unsigned mq_step_t  = 0;
  bit          mq_held    = 1'b1;
  bit          mq_over    = 1'b0;

  int unsigned cfg_window = WINDOW_CHARS_RST;
  int unsigned cfg_scroll = SCROLL_INT_RST;
  int unsigned cfg_pause  = PAUSE_INT_RST;
  bit          cfg_loop   = LOOP_MODE_RST;
  bit          cfg_smooth = SMOOTH_MODE_RST;
  int unsigned cfg_glyph  = GLYPH_PIX_RST;

  out_item_t   window_q [$];     // predicted window characters, oldest first

  int unsigned items_sent     = 0;
  int unsigned cmd_seen [4]   = '{default: 0};
  int unsigned window_updates = 0;
  int unsigned chars_checked  = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned long_hold      = 0;
  bit          calm           = 1'b0;

  // visible width with out-of-range settings folded into 1..WINDOW_MAX
  function automatic int unsigned shown_width();
    if (cfg_window < 1) return 1;
    if (cfg_window > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
    return cfg_window;
  endfunction

  // queue the characters of the current window
  function automatic void push_window();
    logic [7:0]  chars [$];
    int unsigned span, avail, take, rem, k;
    out_item_t   r;
    if (!mq_over) begin
      for (k = 0; k < mq_count && chars.size() < WINDOW_MAX_DEF + 2; k++)
        chars.push_back(mq_text[k]);
    end else begin
      span  = shown_width() + (cfg_smooth ? 1 : 0);
      avail = (mq_start < mq_count) ? mq_count - mq_start : 0;
      take  = (avail < span) ? avail : span;
      for (k = 0; k < take; k++)
        chars.push_back(mq_text[(mq_start + k) % TEXT_DEPTH_DEF]);
      // looped window runs past the end: a space, then the text start again
      if (avail < span && cfg_loop) begin
        rem = span - avail;
        if (rem > mq_count) rem = mq_count;
        chars.push_back(SPACE_CHAR);
        for (k = 0; k < rem; k++)
          chars.push_back(mq_text[k]);
      end
    end
    for (k = 0; k < chars.size(); k++) begin
      r.window_char = chars[k];
      r.window_slot = 6'(k);
      r.window_last = (k + 1 == chars.size());
      r.pixel_shift = (mq_pixel > 15) ? 4'd15 : 4'(mq_pixel);
      r.start_index = 8'(mq_start);
      r.moving      = mq_over && !mq_held;
      window_q.push_back(r);
    end
    if (chars.size() > 0) window_updates++;
  endfunction

  function automatic void apply_command(in_item_t c);
    int unsigned nxt;
    case (c.command)
      CMD_LOAD: begin
        if (c.text_begin) mq_count = 0;
        // full store drops the character, the finish mark still acts
        if (mq_count < TEXT_DEPTH_DEF) begin
          mq_text[mq_count] = c.char_code;
          mq_count++;
        end
        if (c.text_finish) begin
          mq_start   = 0;
          mq_pixel   = 0;
          mq_held    = 1'b1;
          mq_pause_t = 0;
          mq_step_t  = 0;
          mq_over    = (mq_count > shown_width());
          push_window();
        end
      end
      CMD_PAUSE: begin
        mq_held    = 1'b1;
        mq_pause_t = 0;
      end
      CMD_RESUME: begin
        mq_held   = 1'b0;
        mq_step_t = 0;
      end
      CMD_TICK: begin
        if (mq_over && mq_held) begin
          if (mq_pause_t < TIMER_MAX) mq_pause_t++;
          if (mq_pause_t >= cfg_pause) begin
            mq_held   = 1'b0;
            mq_step_t = 0;
          end
        end else if (mq_over) begin
          if (mq_step_t < TIMER_MAX) mq_step_t++;
          if (mq_step_t >= cfg_scroll) begin
            nxt = mq_pixel + SMOOTH_STEP;
            if (cfg_smooth && nxt < cfg_glyph) begin
              mq_pixel = nxt;
            end else begin
              if (cfg_smooth) mq_pixel = 0;
              mq_start++;
              // end of text: wrap to start or park at the tail, then hold
              if (mq_start >= mq_count) begin
                if (cfg_loop) mq_start = 0;
                else mq_start = (mq_count >= shown_width()) ? mq_count - shown_width() : 0;
                mq_held    = 1'b1;
                mq_pause_t = 0;
              end
            end
            mq_step_t = 0;
            push_window();
          end
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_CHARS: cfg_window = val & 'h3F;
      REG_SCROLL_INT:   cfg_scroll = val & 'hFFFF;
      REG_PAUSE_INT:    cfg_pause  = val & 'hFFFF;
      REG_LOOP_MODE:    cfg_loop   = val[0];
      REG_SMOOTH_MODE:  cfg_smooth = val[0];
      REG_GLYPH_PIXELS: cfg_glyph  = val & 'h1F;
      default: ;
    endcase
  endtask

  task automatic send_cmd(cmd_t op, logic [7:0] code, logic first, logic last);
    in_item_t c;
    c.command     = op;
    c.char_code   = code;
    c.text_begin  = first;
    c.text_finish = last;
    if (op != CMD_LOAD) begin
      // only loads look at the other fields; scramble them
      c.char_code   = 8'($urandom);
      c.text_begin  = 1'($urandom_range(0, 1));
      c.text_finish = 1'($urandom_range(0, 1));
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= c;
    do @(posedge clk); while (!in_ready);
    apply_command(c);
    items_sent++;
    cmd_seen[op]++;
  endtask

  // quiet the input and wait out every predicted character
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stall bursts, plus the long hold-off on request
  initial begin : window_sink
    int unsigned stall;
    stall = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        long_hold--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : window_checker
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      chars_checked++;
      if (window_q.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("ERROR: cycle %0d: window char %h slot %0d with nothing expected",
                   cycle_count, out_item.window_char, out_item.window_slot);
        fail_count++;
      end else begin
        want = window_q.pop_front();
        if (out_item.window_char !== want.window_char ||
            out_item.window_slot !== want.window_slot ||
            out_item.window_last !== want.window_last ||
            out_item.pixel_shift !== want.pixel_shift ||
            out_item.start_index !== want.start_index ||
            out_item.moving      !== want.moving) begin
          if (fail_count < REPORT_MAX) begin
            $display("ERROR: cycle %0d: expected char %h slot %0d last %b shift %0d start %0d mov %b",
                     cycle_count, want.window_char, want.window_slot, want.window_last,
                     want.pixel_shift, want.start_index, want.moving);
            $display("       got                  char %h slot %0d last %b shift %0d start %0d mov %b",
                     out_item.window_char, out_item.window_slot, out_item.window_last,
                     out_item.pixel_shift, out_item.start_index, out_item.moving);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d characters still expected",
               cycle_count, window_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset settings: a text that fits shows whole and ignores ticks
  task automatic test_fit_text();
    send_cmd(CMD_LOAD, 8'h41, 1'b1, 1'b1);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_cmd(CMD_LOAD, 8'h00, 1'b1, 1'b0);
    send_cmd(CMD_LOAD, 8'hFF, 1'b0, 1'b1);
  endtask

  // zero width acts as one; whole-character steps; loop wrap back to start
  task automatic test_char_steps();
    settle();
    write_reg(REG_WINDOW_CHARS, 0);
    write_reg(REG_SCROLL_INT, 0);
    write_reg(REG_PAUSE_INT, 0);
    write_reg(REG_SMOOTH_MODE, 0);
    send_cmd(CMD_LOAD, 8'h78, 1'b1, 1'b0);   // "xyz"
    send_cmd(CMD_LOAD, 8'h79, 1'b0, 1'b0);
    send_cmd(CMD_LOAD, 8'h7A, 1'b0, 1'b1);
    repeat (5) send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  // smooth window running past the end shows a space and the text start
  task automatic test_wrap_and_hold();
    settle();
    write_reg(REG_WINDOW_CHARS, 2);
    write_reg(REG_SMOOTH_MODE, 1);
    write_reg(REG_GLYPH_PIXELS, 2);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_cmd(CMD_PAUSE, 8'h00, 1'b0, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_cmd(CMD_RESUME, 8'h00, 1'b0, 1'b0);
  endtask

  // glyph wider than 16 pixels: the reported shift saturates at 15
  task automatic test_pixel_clamp();
    settle();
    write_reg(REG_GLYPH_PIXELS, 31);
    write_reg(REG_WINDOW_CHARS, WINDOW_MAX_DEF + 1);
    repeat (8) send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  // text shrunk under the start: empty window in stop mode, looped part
  // alone in loop mode, then a stop-mode end on a text shorter than the window
  task automatic test_start_past_end();
    settle();
    write_reg(REG_LOOP_MODE, 0);
    send_cmd(CMD_LOAD, 8'h51, 1'b1, 1'b0);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
    settle();
    write_reg(REG_LOOP_MODE, 1);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
    settle();
    write_reg(REG_LOOP_MODE, 0);
    write_reg(REG_SMOOTH_MODE, 0);
    write_reg(REG_WINDOW_CHARS, 8);
    send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  // long receiver hold-off while ticks keep coming: input must stall
  task automatic test_output_backlog();
    int unsigned k;
    settle();
    write_reg(REG_WINDOW_CHARS, WINDOW_MAX_DEF);
    write_reg(REG_SCROLL_INT, 0);
    write_reg(REG_PAUSE_INT, 0);
    write_reg(REG_SMOOTH_MODE, 1);
    write_reg(REG_GLYPH_PIXELS, 4);
    for (k = 0; k < 40; k++)
      send_cmd(CMD_LOAD, 8'($urandom), k == 0, k == 39);
    long_hold = BACKLOG_HOLD;
    repeat (24) send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
  endtask

  // random settings per phase, a text of random content, then mostly ticks
  task automatic test_random_traffic();
    int unsigned base, len, k, pick, roll;
    bit          skip_begin, skip_finish;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      settle();
      if (items_sent - base >= CALM_AFTER) calm = 1'b1;
      pick = $urandom_range(0, 11);
      write_reg(REG_WINDOW_CHARS, pick == 0 ? 0 : pick == 1 ? $urandom_range(33, 63) :
                                  pick == 2 ? WINDOW_MAX_DEF : $urandom_range(1, 10));
      pick = $urandom_range(0, 15);
      write_reg(REG_SCROLL_INT, pick == 0 ? TIMER_MAX : pick == 1 ? $urandom_range(4, 20) :
                                $urandom_range(0, 3));
      pick = $urandom_range(0, 15);
      write_reg(REG_PAUSE_INT, pick == 0 ? TIMER_MAX : pick == 1 ? $urandom_range(5, 30) :
                               $urandom_range(0, 4));
      write_reg(REG_LOOP_MODE, $urandom_range(0, 1));
      write_reg(REG_SMOOTH_MODE, $urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      write_reg(REG_GLYPH_PIXELS, pick == 0 ? 0 : pick == 1 ? $urandom_range(17, 31) :
                                  $urandom_range(1, 8));
      // mostly well-formed texts; now and then one without a start or finish mark
      len         = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
      skip_begin  = ($urandom_range(0, 7) == 0);
      skip_finish = ($urandom_range(0, 7) == 0);
      for (k = 0; k < len; k++)
        send_cmd(CMD_LOAD, 8'($urandom), k == 0 && !skip_begin, k == len - 1 && !skip_finish);
      repeat ($urandom_range(8, 24)) begin
        roll = $urandom_range(0, 99);
        if (roll < 72)
          send_cmd(CMD_TICK, 8'h00, 1'b0, 1'b0);
        else if (roll < 80)
          send_cmd(CMD_PAUSE, 8'h00, 1'b0, 1'b0);
        else if (roll < 88)
          send_cmd(CMD_RESUME, 8'h00, 1'b0, 1'b0);
        else
          send_cmd(CMD_LOAD, 8'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_fit_text();
    test_char_steps();
    test_wrap_and_hold();
    test_pixel_clamp();
    test_start_past_end();
    test_output_backlog();
    test_random_traffic();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d loads, %0d ticks, %0d pauses, %0d resumes",
             items_sent, cmd_seen[CMD_LOAD], cmd_seen[CMD_TICK],
             cmd_seen[CMD_PAUSE], cmd_seen[CMD_RESUME]);
    $display("Checked %0d window characters over %0d window updates, %0d failures",
             chars_checked, window_updates, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
